// ----- design/clbp_pkg.sv -----
// shared constants, register indexes and the pattern compare for the circular lbp stream
// no dependencies; used by the top level and by the testbench
package clbp_pkg;

	// line store geometry
	localparam int LINE_MAX = 1024;
	localparam int LINE_AW  = $clog2(LINE_MAX);

	// field widths
	localparam int PIX_W  = 8;
	localparam int FW_W   = 11;
	localparam int FH_W   = 12;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 12;

	// width used for column compares, wide enough for the register and the store depth
	localparam int CW = (FW_W > LINE_AW + 1) ? FW_W : LINE_AW + 1;

	// register indexes on the config port
	localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd1;

	// register reset values
	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd840;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd473;

	// q0.16 bilinear weights for the diagonal samples, they sum to 65536
	localparam int SUM_W = 25;
	localparam logic [SUM_W-1:0] W_CORNER = 25'd32768;
	localparam logic [SUM_W-1:0] W_SIDE   = 25'd13573;
	localparam logic [SUM_W-1:0] W_CENTRE = 25'd5622;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t win_t [3][3];

	// diagonal sample at least the centre, exact weighted sum against centre*65536
	function automatic logic diag_ge(pix_t corner, pix_t side_a, pix_t side_b, pix_t centre);
		logic [SUM_W-1:0] s;
		logic [SUM_W-1:0] c;
		s = SUM_W'(corner) * W_CORNER
		  + (SUM_W'(side_a) + SUM_W'(side_b)) * W_SIDE
		  + SUM_W'(centre) * W_CENTRE;
		c = {1'b0, centre, 16'd0};
		return s >= c;
	endfunction

endpackage

// ----- design/clbp_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies; used for the two line stores
module clbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/circular_lbp_pixel_stream_top.sv -----
// circular local binary pattern (radius 1, 8 neighbours) over a raster pixel stream
// depends on clbp_pkg and clbp_ram (two line stores)
// a code passes through stage 1 and then the output register on its way to m_tdata
// throughput: one pixel per clock while the code output is not stalled, set by the single line store read per beat
// border pixels (first two rows and columns of the frame) give no code
// reset clears counters, valid flags and the width/height registers (840, 473);
// line stores and window are not cleared; their contents reach a code only after being written
module circular_lbp_pixel_stream_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [clbp_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [clbp_pkg::CFG_DW-1:0]   cfg_data,
	// pixel input
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel
	// code output
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] lbp_code
	output logic                          m_tlast    // end_of_frame
);

	localparam int AW = clbp_pkg::LINE_AW;
	localparam int CW = clbp_pkg::CW;
	localparam int HW = clbp_pkg::FH_W;

	// config registers
	logic [clbp_pkg::FW_W-1:0] frame_width_q;
	logic [HW-1:0]             frame_height_q;

	// position of the next pixel
	logic [AW-1:0] col_q;
	logic [HW-1:0] row_q;

	// stage 1: pixel waiting for its line store data
	logic                  v_s1;
	clbp_pkg::pix_t        px_s1;
	logic [AW-1:0]         col_s1;
	logic                  emit_s1;
	logic                  eof_s1;

	// window and line store read data
	clbp_pkg::win_t win_q;
	clbp_pkg::win_t win_nx;
	clbp_pkg::pix_t up_rd;
	clbp_pkg::pix_t mid_rd;

	logic       accept;
	logic       s1_adv;
	logic [CW-1:0] fw_ext;
	logic [CW-1:0] w_clamp;
	logic [CW-1:0] w_m1;
	logic [HW-1:0] h_clamp;
	logic [HW-1:0] h_m1;
	logic          last_col;
	logic          last_row;
	logic          emit;
	logic [7:0]    code;

	assign cfg_ready = 1'b1;

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= clbp_pkg::FRAME_WIDTH_RST;
			frame_height_q <= clbp_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				clbp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[clbp_pkg::FW_W-1:0];
				clbp_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[HW-1:0];
				default: ;
			endcase
		end
	end

	// clamped frame size and end of row / frame flags
	always_comb begin
		fw_ext = CW'(frame_width_q);
		if (fw_ext < CW'(3)) begin
			w_clamp = CW'(3);
		end else if (fw_ext > CW'(clbp_pkg::LINE_MAX)) begin
			w_clamp = CW'(clbp_pkg::LINE_MAX);
		end else begin
			w_clamp = fw_ext;
		end
		w_m1 = w_clamp - CW'(1);
		h_clamp = (frame_height_q < HW'(3)) ? HW'(3) : frame_height_q;
		h_m1 = h_clamp - HW'(1);
		last_col = CW'(col_q) >= w_m1;
		last_row = row_q >= h_m1;
		emit = (row_q >= HW'(2)) && (col_q >= AW'(2));
	end

	// handshake: stage 1 moves on when its code has room or it gives none
	assign s1_adv   = v_s1 && (!emit_s1 || !m_tvalid || m_tready);
	assign s_tready = !v_s1 || s1_adv;
	assign accept   = s_tvalid && s_tready;

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + HW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= s_tdata;
			col_s1  <= col_q;
			emit_s1 <= emit;
			eof_s1  <= last_col && last_row;
		end
	end

	// line stores: read at accept, rotate rows when stage 1 moves on
	clbp_ram #(
		.WIDTH (clbp_pkg::PIX_W),
		.DEPTH (clbp_pkg::LINE_MAX)
	) u_upper (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (mid_rd),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (up_rd)
	);

	clbp_ram #(
		.WIDTH (clbp_pkg::PIX_W),
		.DEPTH (clbp_pkg::LINE_MAX)
	) u_middle (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (px_s1),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (mid_rd)
	);

	// next window: shift left, new column from the stores and the pixel
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_nx[r][0] = win_q[r][1];
			win_nx[r][1] = win_q[r][2];
		end
		win_nx[0][2] = up_rd;
		win_nx[1][2] = mid_rd;
		win_nx[2][2] = px_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			win_q <= win_nx;
		end
	end

	// pattern code; rows 0..2 are oldest..newest, centre at [1][1]
	always_comb begin
		code[0] = win_nx[2][1] >= win_nx[1][1];
		code[1] = clbp_pkg::diag_ge(win_nx[2][0], win_nx[2][1], win_nx[1][0], win_nx[1][1]);
		code[2] = win_nx[1][0] >= win_nx[1][1];
		code[3] = clbp_pkg::diag_ge(win_nx[0][0], win_nx[0][1], win_nx[1][0], win_nx[1][1]);
		code[4] = win_nx[0][1] >= win_nx[1][1];
		code[5] = clbp_pkg::diag_ge(win_nx[0][2], win_nx[0][1], win_nx[1][2], win_nx[1][1]);
		code[6] = win_nx[1][2] >= win_nx[1][1];
		code[7] = clbp_pkg::diag_ge(win_nx[2][2], win_nx[2][1], win_nx[1][2], win_nx[1][1]);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			m_tdata <= code;
			m_tlast <= eof_s1;
		end
	end

	// a new read never hits the entry that stage 1 is about to write
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		accept && v_s1 |-> col_q != col_s1)
		else $error("line store read and write at the same column");

	// end of frame only on a beat that carries a code
	a_eof_emits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && eof_s1 |-> emit_s1)
		else $error("end of frame on a border pixel");

	// an accepted beat always occupies stage 1 next cycle
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted pixel lost before stage 1");

	// a waiting code is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !(s1_adv && emit_s1))
		else $error("code overwritten while stalled");

endmodule

// ----- tb/tb_circular_lbp_pixel_stream_top.sv -----
// self-checking testbench for circular_lbp_pixel_stream_top, radius 1 lbp over a pixel stream
// depends on clbp_pkg and the design; models line stores, window and counters to predict codes
`timescale 1ns / 1ps

module tb_circular_lbp_pixel_stream_top;

	typedef struct packed {
		logic [7:0] code;
		logic       eof;
	} lbp_result_t;

	typedef enum int {PIX_UNIFORM, PIX_FLAT, PIX_BINARY} pixel_mix_t;

	localparam int FIFO_DEPTH = 16;

	// hand-made 3 x 8 frame: alternating extremes, then a flat patch with one dark pixel, then a mixed row
	localparam logic [7:0] DIRECTED_PIX [24] = '{
		8'd0,   8'd255, 8'd0,
		8'd255, 8'd0,   8'd255,
		8'd0,   8'd255, 8'd0,
		8'd255, 8'd0,   8'd255,
		8'd100, 8'd100, 8'd100,
		8'd100, 8'd100, 8'd99,
		8'd100, 8'd100, 8'd100,
		8'd1,   8'd254, 8'd128
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [clbp_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [clbp_pkg::CFG_DW-1:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	// predicted state of the block
	bit   [7:0]  upper_row  [clbp_pkg::LINE_MAX];
	bit   [7:0]  middle_row [clbp_pkg::LINE_MAX];
	bit   [7:0]  window [3][3];
	int          col_pos;
	int          row_pos;
	logic [10:0] width_reg;
	logic [11:0] height_reg;

	// predicted codes in order, written by the driver and read by the checker
	lbp_result_t code_fifo [FIFO_DEPTH];
	int          codes_in  = 0;
	int          codes_out = 0;
	int          mismatches;
	int          pixels_sent;
	bit          idle_on;

	circular_lbp_pixel_stream_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	// output back-pressure
	always @(posedge clk) begin
		m_tready <= !idle_on || ($urandom_range(0, 99) >= 38);
	end

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		mismatches++;
	endtask

	function automatic int eff_width();
		if (width_reg < 3)
			return 3;
		if (width_reg > clbp_pkg::LINE_MAX)
			return clbp_pkg::LINE_MAX;
		return int'(width_reg);
	endfunction

	// code of the current window: axis neighbours exact, diagonals bilinear in q0.16
	function automatic logic [7:0] pattern_code();
		int ring_dr [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
		int ring_dc [8] = '{0, -1, -1, -1, 0, 1, 1, 1};
		int unsigned centre;
		int unsigned sample;
		int dr;
		int dc;
		logic [7:0] code;
		centre = 32'(window[1][1]);
		code = '0;
		for (int n = 0; n < 8; n++) begin
			dr = ring_dr[n];
			dc = ring_dc[n];
			if (dr == 0 || dc == 0) begin
				sample = int'(window[1+dr][1+dc]) * 65536;
			end else begin
				sample = 32768 * int'(window[1+dr][1+dc])
				       + 13573 * (int'(window[1+dr][1]) + int'(window[1][1+dc]))
				       + 5622 * centre;
			end
			code[n] = (sample >= centre * 65536);
		end
		return code;
	endfunction

	// advance the predicted state by one accepted pixel
	task automatic take_pixel(input logic [7:0] px);
		int w;
		int h;
		bit [7:0] up;
		bit [7:0] mid;
		bit last_col;
		bit last_row;
		lbp_result_t res;
		w = eff_width();
		h = (height_reg < 3) ? 3 : int'(height_reg);
		up = upper_row[col_pos];
		mid = middle_row[col_pos];
		upper_row[col_pos] = mid;
		middle_row[col_pos] = px;
		for (int r = 0; r < 3; r++) begin
			window[r][0] = window[r][1];
			window[r][1] = window[r][2];
		end
		window[0][2] = up;
		window[1][2] = mid;
		window[2][2] = px;
		last_col = col_pos >= w - 1;
		last_row = row_pos >= h - 1;
		if (row_pos >= 2 && col_pos >= 2) begin
			res.code = pattern_code();
			res.eof = last_col && last_row;
			code_fifo[codes_in % FIFO_DEPTH] = res;
			codes_in++;
		end
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	function automatic logic [7:0] noise_pixel(input pixel_mix_t mix, input int base);
		int v;
		case (mix)
			PIX_UNIFORM: begin
				return 8'($urandom_range(0, 255));
			end
			PIX_FLAT: begin
				v = base + int'($urandom_range(0, 4)) - 2;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
				return 8'(v);
			end
			default: begin
				return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
		endcase
	endfunction

	// one pixel beat, with random gaps in front of it while idle_on is set
	task automatic send_pixel(input logic [7:0] px);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 38) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		take_pixel(px);
		pixels_sent++;
	endtask

	// stop the stream and let every pending code come out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (codes_in != codes_out)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [clbp_pkg::CFG_IW-1:0] idx,
			input logic [clbp_pkg::CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == clbp_pkg::REG_FRAME_WIDTH)
			width_reg = val[10:0];
		else if (idx == clbp_pkg::REG_FRAME_HEIGHT)
			height_reg = val;
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [11:0] w, input logic [11:0] h);
		settle();
		write_reg(clbp_pkg::REG_FRAME_WIDTH, w);
		write_reg(clbp_pkg::REG_FRAME_HEIGHT, h);
	endtask

	// send pixels until the frame counters wrap
	task automatic finish_frame(input pixel_mix_t mix, input int base);
		do begin
			send_pixel(noise_pixel(mix, base));
		end while (col_pos != 0 || row_pos != 0);
	endtask

	// reset sizes 840 x 473: no early row end, then cut the frame short with both registers
	task automatic test_reset_values();
		repeat (20)
			send_pixel(noise_pixel(PIX_UNIFORM, 0));
		settle();
		write_reg(clbp_pkg::REG_FRAME_HEIGHT, 12'd3);
		write_reg(clbp_pkg::REG_FRAME_WIDTH, 12'd12);
		finish_frame(PIX_UNIFORM, 0);
	endtask

	task automatic test_directed_patterns();
		set_frame(12'd3, 12'd8);
		for (int i = 0; i < 24; i++)
			send_pixel(DIRECTED_PIX[i]);
	endtask

	// clamped sizes, a start on the widest line and a start on the tallest frame
	task automatic test_register_limits();
		set_frame(12'h000, 12'h001);
		finish_frame(PIX_UNIFORM, 0);
		set_frame(12'hFFF, 12'h000);
		repeat (40)
			send_pixel(noise_pixel(PIX_BINARY, 0));
		settle();
		write_reg(clbp_pkg::REG_FRAME_WIDTH, 12'h003);
		finish_frame(PIX_BINARY, 0);
		set_frame(12'hC00, 12'h002);
		repeat (30)
			send_pixel(noise_pixel(PIX_FLAT, 128));
		settle();
		write_reg(clbp_pkg::REG_FRAME_WIDTH, 12'h003);
		finish_frame(PIX_FLAT, 128);
		// run with no gaps or stalls on either side
		idle_on = 1'b0;
		set_frame(12'h003, 12'hFFF);
		repeat (60)
			send_pixel(noise_pixel(PIX_UNIFORM, 0));
		settle();
		write_reg(clbp_pkg::REG_FRAME_HEIGHT, 12'h003);
		finish_frame(PIX_UNIFORM, 0);
		idle_on = 1'b1;
	endtask

	// shrink the width or change the height part way through a frame
	task automatic test_mid_frame_change();
		int w;
		int h;
		int cut;
		repeat (3) begin
			w = $urandom_range(6, 14);
			h = $urandom_range(4, 7);
			set_frame(12'(w), 12'(h));
			cut = $urandom_range(1, w * h - 1);
			repeat (cut)
				send_pixel(noise_pixel(PIX_UNIFORM, 0));
			settle();
			if ($urandom_range(0, 1))
				write_reg(clbp_pkg::REG_FRAME_WIDTH, 12'($urandom_range(0, eff_width())));
			if ($urandom_range(0, 1))
				write_reg(clbp_pkg::REG_FRAME_HEIGHT, 12'($urandom_range(0, 12)));
			finish_frame(pixel_mix_t'($urandom_range(0, 2)), $urandom_range(0, 255));
		end
	endtask

	// whole frames of random size and content
	task automatic test_random_frames();
		int start;
		int w;
		start = pixels_sent;
		while (pixels_sent - start < 230) begin
			idle_on = !(pixels_sent - start >= 100 && pixels_sent - start < 200);
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(3, 16);
			set_frame(12'(w), 12'($urandom_range(3, 6)));
			finish_frame(pixel_mix_t'($urandom_range(0, 2)), $urandom_range(0, 255));
		end
		idle_on = 1'b1;
	endtask

	// compare each code beat with the oldest prediction
	always @(posedge clk) begin
		lbp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (codes_in == codes_out) begin
				report_mismatch("unexpected code beat", 0, m_tdata);
			end else begin
				want = code_fifo[codes_out % FIFO_DEPTH];
				codes_out++;
				if (m_tdata !== want.code)
					report_mismatch("lbp_code", want.code, m_tdata);
				if (m_tlast !== want.eof)
					report_mismatch("end_of_frame", want.eof, m_tlast);
			end
		end
	end

	initial begin
		idle_on = 1'b1;
		mismatches = 0;
		pixels_sent = 0;
		col_pos = 0;
		row_pos = 0;
		width_reg = clbp_pkg::FRAME_WIDTH_RST;
		height_reg = clbp_pkg::FRAME_HEIGHT_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed_patterns();
		test_register_limits();
		test_mid_frame_change();
		test_random_frames();
		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
